// ----- rtl/core/lfec_pkg.sv -----
// ----------------------------------------------------------------------------
// lfec_pkg: shared types and constants for the edge-clamped line FIR
// Stage control bundle and fixed field widths used across the pipeline.
// ----------------------------------------------------------------------------
package lfec_pkg;

   localparam int OUT_BITS    = 32;
   localparam int WEIGHT_BITS = 16;

   // control that rides along with a result through the pipeline
   typedef struct packed {
      logic valid;
      logic done;
   } lfec_ctl_type;

endpackage

// ----- rtl/core/lfec_tap_seq.sv -----
// ----------------------------------------------------------------------------
// lfec_tap_seq: sample window, line-end flush sequencer and tap select
// Shifts accepted samples into the window, decides which output positions
// to compute and registers the edge-clamped neighbors of each one.
// ----------------------------------------------------------------------------
module lfec_tap_seq #(
   parameter int MAX_OFFSET  = 3,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [SAMPLE_BITS-1:0]            req_sample,
   input  logic                                     req_line_end,
   input  logic                                     dn_ready,
   output lfec_pkg::lfec_ctl_type                   tap_ctl,
   output logic [2*MAX_OFFSET:0][SAMPLE_BITS-1:0]   tap_data
);

   localparam int TAPS = 2 * MAX_OFFSET + 1;
   localparam int CW   = $clog2(TAPS + 1);
   localparam int BW   = $clog2(MAX_OFFSET + 1);
   localparam int OW   = $clog2(TAPS);
   localparam int DW   = $clog2(3 * MAX_OFFSET + 1) + 1;

   logic [TAPS-1:0][SAMPLE_BITS-1:0] window_ff, window_in;
   logic [CW-1:0]                    filled_ff, filled_in;
   logic [BW-1:0]                    flush_rem_ff, flush_rem_in;
   logic [OW-1:0]                    flush_oldest_ff, flush_oldest_in;
   lfec_pkg::lfec_ctl_type           tap_ctl_ff, tap_ctl_in;
   logic [TAPS-1:0][SAMPLE_BITS-1:0] tap_data_ff, tap_data_in;

   logic          flushing;
   logic          load_ok;
   logic          accept;
   logic [CW-1:0] filled_inc;
   logic [CW-1:0] filled_last;
   logic          job_go;
   logic [BW-1:0] job_back;
   logic [OW-1:0] job_oldest;

   assign flushing   = (flush_rem_ff != '0);
   assign load_ok    = !tap_ctl_ff.valid || dn_ready;
   assign req_stall  = flushing || !load_ok;
   assign accept     = req_valid && !req_stall;
   assign filled_inc = (filled_ff < CW'(TAPS)) ? filled_ff + 1'b1 : filled_ff;
   assign filled_last = filled_inc - 1'b1;

   always_comb begin
      window_in = window_ff;
      if (accept) begin
         for (int i = 0; i < TAPS - 1; i++) begin
            window_in[i] = window_ff[i+1];
         end
         window_in[TAPS-1] = req_sample;
      end
   end

   // pick next position: flush beat, or one per sample past MAX_OFFSET or line end
   always_comb begin
      job_go          = 1'b0;
      job_back        = '0;
      job_oldest      = '0;
      filled_in       = filled_ff;
      flush_rem_in    = flush_rem_ff;
      flush_oldest_in = flush_oldest_ff;
      if (flushing) begin
         if (load_ok) begin
            job_go       = 1'b1;
            job_back     = flush_rem_ff - 1'b1;
            job_oldest   = flush_oldest_ff;
            flush_rem_in = flush_rem_ff - 1'b1;
         end
      end else if (accept) begin
         job_oldest = filled_last[OW-1:0];
         if (req_line_end) begin
            job_go          = 1'b1;
            job_back        = (filled_last > CW'(MAX_OFFSET)) ? BW'(MAX_OFFSET)
                                                              : filled_last[BW-1:0];
            flush_rem_in    = job_back;
            flush_oldest_in = filled_last[OW-1:0];
            filled_in       = '0;
         end else begin
            filled_in = filled_inc;
            if (filled_inc >= CW'(MAX_OFFSET + 1)) begin
               job_go   = 1'b1;
               job_back = BW'(MAX_OFFSET);
            end
         end
      end
   end

   // neighbor at offset k - MAX_OFFSET sits at distance back - offset from the newest
   always_comb begin
      logic signed [DW-1:0] span;
      logic [OW-1:0]        idx;
      tap_ctl_in.valid = job_go;
      tap_ctl_in.done  = (job_back == '0);
      for (int k = 0; k < TAPS; k++) begin
         span = signed'(DW'(job_back)) + signed'(DW'(MAX_OFFSET)) - signed'(DW'(k));
         if (span < 0) begin
            span = '0;
         end else if (span > signed'(DW'(job_oldest))) begin
            span = signed'(DW'(job_oldest));
         end
         idx            = OW'(TAPS - 1) - span[OW-1:0];
         tap_data_in[k] = window_in[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff       <= '0;
         filled_ff       <= '0;
         flush_rem_ff    <= '0;
         flush_oldest_ff <= '0;
         tap_ctl_ff      <= '0;
      end else begin
         window_ff       <= window_in;
         filled_ff       <= filled_in;
         flush_rem_ff    <= flush_rem_in;
         flush_oldest_ff <= flush_oldest_in;
         if (load_ok) begin
            tap_ctl_ff <= tap_ctl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok) begin
         tap_data_ff <= tap_data_in;
      end
   end

   assign tap_ctl  = tap_ctl_ff;
   assign tap_data = tap_data_ff;

   a_line_end_issues: assert property (@(posedge clock) disable iff (reset)
      accept && req_line_end |=> tap_ctl_ff.valid && filled_ff == '0)
      else $error("line end beat did not issue a result or clear the fill count");

   a_flush_counts_down: assert property (@(posedge clock) disable iff (reset)
      flushing && load_ok |=> flush_rem_ff == BW'($past(flush_rem_ff) - 1'b1))
      else $error("flush counter did not step down");

   a_filled_range: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CW'(TAPS))
      else $error("fill count beyond window depth");

endmodule

// ----- rtl/core/lfec_mac.sv -----
// ----------------------------------------------------------------------------
// lfec_mac: tap multiply and sum pipeline
// Registers the 2*MAX_OFFSET+1 weight products, then their full-width sum.
// ----------------------------------------------------------------------------
module lfec_mac #(
   parameter int MAX_OFFSET  = 3,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  lfec_pkg::lfec_ctl_type                                 up_ctl,
   input  logic [2*MAX_OFFSET:0][SAMPLE_BITS-1:0]                 up_taps,
   input  logic [2*MAX_OFFSET:0][lfec_pkg::WEIGHT_BITS-1:0]       weights,
   output logic                                                   up_ready,
   input  logic                                                   dn_ready,
   output lfec_pkg::lfec_ctl_type                                 sum_ctl,
   output logic signed [SAMPLE_BITS+lfec_pkg::WEIGHT_BITS+$clog2(2*MAX_OFFSET+1)-1:0] sum
);

   localparam int TAPS = 2 * MAX_OFFSET + 1;
   localparam int PW   = SAMPLE_BITS + lfec_pkg::WEIGHT_BITS;
   localparam int AW   = PW + $clog2(TAPS);

   lfec_pkg::lfec_ctl_type prod_ctl_ff, sum_ctl_ff;
   logic signed [PW-1:0]   prod_ff [TAPS];
   logic signed [PW-1:0]   prod_in [TAPS];
   logic signed [AW-1:0]   sum_ff, sum_in;
   logic                   prod_rdy, sum_rdy;

   assign sum_rdy  = !sum_ctl_ff.valid || dn_ready;
   assign prod_rdy = !prod_ctl_ff.valid || sum_rdy;
   assign up_ready = prod_rdy;

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         prod_in[k] = PW'($signed(up_taps[k])) * PW'($signed(weights[k]));
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < TAPS; k++) begin
         sum_in = sum_in + AW'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctl_ff <= '0;
         sum_ctl_ff  <= '0;
      end else begin
         if (prod_rdy) begin
            prod_ctl_ff <= up_ctl;
         end
         if (sum_rdy) begin
            sum_ctl_ff <= prod_ctl_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_rdy) begin
         prod_ff <= prod_in;
      end
      if (sum_rdy) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_ctl = sum_ctl_ff;
   assign sum     = sum_ff;

endmodule

// ----- rtl/core/lfec_sat_out.sv -----
// ----------------------------------------------------------------------------
// lfec_sat_out: scale, saturate and result register
// Drops the weight fraction (floor), clamps to 32-bit signed and holds the beat.
// ----------------------------------------------------------------------------
module lfec_sat_out #(
   parameter int MAX_OFFSET  = 3,
   parameter int SAMPLE_BITS = 24,
   parameter int WEIGHT_FRAC = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lfec_pkg::lfec_ctl_type               sum_ctl,
   input  logic signed [SAMPLE_BITS+lfec_pkg::WEIGHT_BITS+$clog2(2*MAX_OFFSET+1)-1:0] sum,
   output logic                                 dn_ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lfec_pkg::OUT_BITS-1:0] rsp_filtered,
   output logic                                 rsp_line_done
);

   localparam int AW = SAMPLE_BITS + lfec_pkg::WEIGHT_BITS + $clog2(2 * MAX_OFFSET + 1);
   localparam int OB = lfec_pkg::OUT_BITS;
   localparam int EW = (AW > OB + 1) ? AW : OB + 1;

   logic signed [EW-1:0] ext;
   logic signed [EW-1:0] scaled;
   logic [EW-OB:0]       high_bits;
   logic [OB-1:0]        sat_val;
   logic                 out_valid_ff;
   logic                 out_done_ff;
   logic [OB-1:0]        out_data_ff;

   assign ext       = EW'(sum);
   assign scaled    = ext >>> WEIGHT_FRAC;
   assign high_bits = scaled[EW-1:OB-1];

   always_comb begin
      if ((&high_bits) || !(|high_bits)) begin
         sat_val = scaled[OB-1:0];
      end else if (scaled[EW-1]) begin
         sat_val = {1'b1, {(OB-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(OB-1){1'b1}}};
      end
   end

   assign dn_ready = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (dn_ready) begin
         out_valid_ff <= sum_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dn_ready) begin
         out_done_ff <= sum_ctl.done;
         out_data_ff <= sat_val;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_line_done = out_done_ff;
   assign rsp_filtered  = out_data_ff;

endmodule

// ----- rtl/core/line_fir_edge_clamped_unit.sv -----
// ----------------------------------------------------------------------------
// line_fir_edge_clamped_unit: 1-D FIR over a streamed line, edges replicated
// Samples of a line enter on req_, one beat per position, req_line_end on
// the last. Each result on rsp_ is the sum of weight * neighbor over offsets
// -MAX_OFFSET..+MAX_OFFSET, neighbors past either end taking the end sample,
// shifted right by WEIGHT_FRAC (floor) and clamped to 32-bit signed.
// Results trail the input by MAX_OFFSET positions; the line-end beat releases
// the remaining positions (up to MAX_OFFSET+1), rsp_line_done on the last.
// Weights are written on csr_ (index 0 is offset -MAX_OFFSET); the user must
// write them only while idle, which the block itself does not enforce.
// Throughput: one sample beat per cycle while req_stall is low. After a
// line-end beat req_stall stays high while flush results remain (at most
// MAX_OFFSET), issued one per cycle from the window unless stalled. A result
// beat passes the tap, product, sum and result registers on its way to rsp_.
// rsp_stall holds the result register; the pipeline keeps filling its empty
// stages and raises req_stall only once every stage holds a beat.
// Reset clears the window, fill count, weights and all valid flags.
// ----------------------------------------------------------------------------
module line_fir_edge_clamped_unit #(
   parameter int MAX_OFFSET  = 3,
   parameter int SAMPLE_BITS = 24,
   parameter int WEIGHT_FRAC = 12
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic signed [SAMPLE_BITS-1:0]                req_sample,
   input  logic                                         req_line_end,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic signed [lfec_pkg::OUT_BITS-1:0]         rsp_filtered,
   output logic                                         rsp_line_done,
   input  logic                                         csr_write_en,
   input  logic [$clog2(2*MAX_OFFSET+1)-1:0]            csr_index,
   input  logic [lfec_pkg::WEIGHT_BITS-1:0]             csr_wdata
);

   localparam int TAPS = 2 * MAX_OFFSET + 1;
   localparam int IW   = $clog2(TAPS);
   localparam int AW   = SAMPLE_BITS + lfec_pkg::WEIGHT_BITS + $clog2(TAPS);

   logic [TAPS-1:0][lfec_pkg::WEIGHT_BITS-1:0] weight_ff;
   lfec_pkg::lfec_ctl_type                     tap_ctl, sum_ctl;
   logic [TAPS-1:0][SAMPLE_BITS-1:0]           tap_data;
   logic signed [AW-1:0]                       sum;
   logic                                       mac_ready;
   logic                                       out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
      end else if (csr_write_en && (csr_index < IW'(TAPS))) begin
         weight_ff[csr_index] <= csr_wdata;
      end
   end

   lfec_tap_seq #(
      .MAX_OFFSET  (MAX_OFFSET),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_tap_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .req_line_end (req_line_end),
      .dn_ready     (mac_ready),
      .tap_ctl      (tap_ctl),
      .tap_data     (tap_data)
   );

   lfec_mac #(
      .MAX_OFFSET  (MAX_OFFSET),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .up_ctl   (tap_ctl),
      .up_taps  (tap_data),
      .weights  (weight_ff),
      .up_ready (mac_ready),
      .dn_ready (out_ready),
      .sum_ctl  (sum_ctl),
      .sum      (sum)
   );

   lfec_sat_out #(
      .MAX_OFFSET  (MAX_OFFSET),
      .SAMPLE_BITS (SAMPLE_BITS),
      .WEIGHT_FRAC (WEIGHT_FRAC)
   ) u_sat_out (
      .clock         (clock),
      .reset         (reset),
      .sum_ctl       (sum_ctl),
      .sum           (sum),
      .dn_ready      (out_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_filtered  (rsp_filtered),
      .rsp_line_done (rsp_line_done)
   );

endmodule
